/* src/gnos_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gnos_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int COORD_BITS    = 12;

  localparam logic [15:0] SCALE_MIN  = 16'd205;
  localparam logic [15:0] SCALE_MAX  = 16'd32768;
  localparam logic [12:0] REGION_MAX = 13'd4096;

  // Offset 0.94 in Q.30 and factor 0.526 / 1.0 in Q.16.
  localparam logic [44:0] OFFSET_Q30   = 45'd1009317315;
  localparam logic [16:0] FACTOR_Q16   = 17'd34473;
  localparam logic [16:0] FACTOR_UNITY = 17'd65536;

  typedef enum logic [1:0] {
    OP_LOAD_PERM = 2'd0,
    OP_LOAD_GRAD = 2'd1,
    OP_EVAL      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_TILE     = 3'd0,
    CFG_TURB     = 3'd1,
    CFG_DETAIL   = 3'd2,
    CFG_XSCALE   = 3'd3,
    CFG_YSCALE   = 3'd4,
    CFG_RWIDTH   = 3'd5,
    CFG_RHEIGHT  = 3'd6,
    CFG_RESERVED = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MX,
    ST_DIVX,
    ST_MY,
    ST_DIVY,
    ST_QX,
    ST_DIVQX,
    ST_QY,
    ST_DIVQY,
    ST_OINIT,
    ST_SQ,
    ST_CU,
    ST_WF,
    ST_RP,
    ST_CP,
    ST_GR,
    ST_WXY,
    ST_DOTX,
    ST_DOTY,
    ST_PROD,
    ST_OACC,
    ST_FADD,
    ST_FMUL,
    ST_FOUT
  } state_t;

endpackage

`default_nettype wire

/* src/gradient_noise_octave_sum_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  operation, table_index, perm_value,
//                                          grad_x, grad_y, column, row
// out_     output     out_valid/out_stall  gray_value
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Table loads are accepted while the sequencer is idle. A pixel first runs
// the two restoring divisions that map column and row to lattice space (plus
// two more in tile mode for the lattice wrap residues), then one pass per
// octave through the single shared multiplier that serves the weights, the dot
// products and the blend, and finally offset, scaling and saturation.
// Reset is synchronous and active low; it restores the register defaults and
// idles the sequencer. The tables hold nothing until they are loaded.
// A finished gray value waits in the output register while the next item is
// accepted; the sequencer only stalls at its last step if that register is full.

module gradient_noise_octave_sum_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_operation,
  input  wire logic [gnos_pkg::TBL_IDX_W-1:0]   in_table_index,
  input  wire logic [gnos_pkg::TBL_IDX_W-1:0]   in_perm_value,
  input  wire logic signed [15:0]               in_grad_x,
  input  wire logic signed [15:0]               in_grad_y,
  input  wire logic [gnos_pkg::COORD_BITS-1:0]  in_column,
  input  wire logic [gnos_pkg::COORD_BITS-1:0]  in_row,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_gray_value,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [2:0]                       cfg_index,
  input  wire logic [15:0]                      cfg_data
);

  localparam int IW = gnos_pkg::TBL_IDX_W;
  localparam int CB = gnos_pkg::COORD_BITS;

  // Configuration registers, held as written.
  logic        tile_r, turb_r;
  logic [3:0]  detail_r;
  logic [15:0] xscale_r, yscale_r;
  logic [12:0] rw_r, rh_r;

  // Sequencer and datapath registers.
  gnos_pkg::state_t state_r, state_nxt;
  logic [CB-1:0]       col_r, row_r;
  logic [32:0]         dvd_r;
  logic [11:0]         rem_r;
  logic [12:0]         dsr_r;
  logic [5:0]          dcnt_r;
  logic [47:0]         pxs_r, pys_r;
  logic [19:0]         am_r, bm_r, mx_r, my_r;
  logic [3:0]          oct_r;
  logic [1:0]          wsel_r, k_r;
  logic [32:0]         sq_r;
  logic [48:0]         cube_r;
  logic [16:0]         w_r [4];
  logic [16:0]         wxy_r;
  logic signed [33:0]  dot_r;
  logic signed [55:0]  osum_r;
  logic signed [43:0]  acc_r;
  logic [31:0]         vc_r;
  logic                vpos_r;
  logic [47:0]         fprod_r;
  logic                out_valid_r;
  logic [7:0]          gray_r;

  // Table memories with registered reads.
  logic [IW-1:0] perm_mem [gnos_pkg::TABLE_ENTRIES];
  logic [15:0]   gx_mem   [gnos_pkg::TABLE_ENTRIES];
  logic [15:0]   gy_mem   [gnos_pkg::TABLE_ENTRIES];
  logic [IW-1:0] perm_q_r;
  logic [15:0]   gx_q_r, gy_q_r;
  logic          perm_re, grad_re;
  logic [IW-1:0] perm_ra;

  logic in_acc;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != gnos_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_gray_value = gray_r;

  // Effective scales and region sizes after clamping and tile rounding.
  logic [15:0] xs_cl, ys_cl, xs_eff, ys_eff;
  logic [16:0] xs_rnd, ys_rnd, xs_up, ys_up;
  logic [4:0]  xclip, yclip;
  logic [12:0] rw_cl, rh_cl;

  always_comb begin
    xs_cl = (xscale_r < gnos_pkg::SCALE_MIN) ? gnos_pkg::SCALE_MIN :
            (xscale_r > gnos_pkg::SCALE_MAX) ? gnos_pkg::SCALE_MAX : xscale_r;
    ys_cl = (yscale_r < gnos_pkg::SCALE_MIN) ? gnos_pkg::SCALE_MIN :
            (yscale_r > gnos_pkg::SCALE_MAX) ? gnos_pkg::SCALE_MAX : yscale_r;
    xs_rnd = {1'b0, xs_cl} + 17'd2047;
    ys_rnd = {1'b0, ys_cl} + 17'd2047;
    xs_up  = {xs_rnd[16:11], 11'b0};
    ys_up  = {ys_rnd[16:11], 11'b0};
    xclip  = xs_up[15:11];
    yclip  = ys_up[15:11];
    xs_eff = tile_r ? xs_up[15:0] : xs_cl;
    ys_eff = tile_r ? ys_up[15:0] : ys_cl;
    rw_cl  = (rw_r == 13'd0) ? 13'd1 :
             (rw_r > gnos_pkg::REGION_MAX) ? gnos_pkg::REGION_MAX : rw_r;
    rh_cl  = (rh_r == 13'd0) ? 13'd1 :
             (rh_r > gnos_pkg::REGION_MAX) ? gnos_pkg::REGION_MAX : rh_r;
  end

  // One restoring division step per cycle.
  logic [12:0] rem_sh, rem_diff;
  logic        div_ge, div_last;
  logic [11:0] rem_nxt;
  logic [32:0] quo_nxt;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[32]};
    div_ge   = (rem_sh >= dsr_r);
    rem_diff = rem_sh - dsr_r;
    rem_nxt  = div_ge ? rem_diff[11:0] : rem_sh[11:0];
    quo_nxt  = {dvd_r[31:0], div_ge};
    div_last = (dcnt_r == 6'd32);
  end

  // Lattice fractions, corner offsets and weight selection.
  logic [15:0]        fx, fy;
  logic [16:0]        u;
  logic               ci, cj;
  logic signed [17:0] vx, vy;
  logic [16:0]        wx, wy;
  logic [51:0]        wnum;

  always_comb begin
    fx = pxs_r[15:0];
    fy = pys_r[15:0];
    unique case (wsel_r)
      2'd0:    u = {1'b0, fx};
      2'd1:    u = 17'd65536 - {1'b0, fx};
      2'd2:    u = {1'b0, fy};
      default: u = 17'd65536 - {1'b0, fy};
    endcase
    ci = k_r[1];
    cj = k_r[0];
    vx = $signed({2'b00, fx}) - (ci ? 18'sd65536 : 18'sd0);
    vy = $signed({2'b00, fy}) - (cj ? 18'sd65536 : 18'sd0);
    wx = ci ? w_r[1] : w_r[0];
    wy = cj ? w_r[3] : w_r[2];
    // 1 - 3t^2 + 2|t|^3 with t in Q.16; the total never goes negative.
    wnum = (52'd1 << 48) + {2'b0, cube_r, 1'b0}
         - {2'b0, sq_r, 17'b0} - {3'b0, sq_r, 16'b0};
  end

  // Lattice cell indices. In tile mode the running residues wrap at the
  // per-octave period; otherwise only the low index bits matter.
  logic [20:0]   rt, ct;
  logic [IW-1:0] row_ix, col_ix;

  always_comb begin
    rt = {1'b0, bm_r} + {20'b0, cj};
    ct = {1'b0, am_r} + {20'b0, ci};
    if (tile_r) begin
      row_ix = (rt == {1'b0, my_r}) ? '0 : rt[IW-1:0];
      col_ix = (ct == {1'b0, mx_r}) ? '0 : ct[IW-1:0];
    end else begin
      row_ix = pys_r[16+IW-1:16] + IW'(cj);
      col_ix = pxs_r[16+IW-1:16] + IW'(ci);
    end
  end

  // The shared multiplier.
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      gnos_pkg::ST_MX: begin
        mul_a = $signed({{(35-CB){1'b0}}, col_r});
        mul_b = $signed({2'b0, xs_eff});
      end
      gnos_pkg::ST_MY: begin
        mul_a = $signed({{(35-CB){1'b0}}, row_r});
        mul_b = $signed({2'b0, ys_eff});
      end
      gnos_pkg::ST_SQ: begin
        mul_a = $signed({18'b0, u});
        mul_b = $signed({1'b0, u});
      end
      gnos_pkg::ST_CU: begin
        mul_a = $signed({2'b0, sq_r});
        mul_b = $signed({1'b0, u});
      end
      gnos_pkg::ST_WXY: begin
        mul_a = $signed({18'b0, wx});
        mul_b = $signed({1'b0, wy});
      end
      gnos_pkg::ST_DOTX: begin
        mul_a = 35'(signed'(gx_q_r));
        mul_b = vx;
      end
      gnos_pkg::ST_DOTY: begin
        mul_a = 35'(signed'(gy_q_r));
        mul_b = vy;
      end
      gnos_pkg::ST_PROD: begin
        mul_a = 35'(dot_r);
        mul_b = $signed({1'b0, wxy_r});
      end
      gnos_pkg::ST_FMUL: begin
        mul_a = $signed({3'b0, vc_r});
        mul_b = $signed({1'b0, turb_r ? gnos_pkg::FACTOR_UNITY : gnos_pkg::FACTOR_Q16});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Octave value, floor-shifted by 16 plus the octave index; abs if turb_r.
  logic signed [55:0] osh;
  logic signed [39:0] oval;
  always_comb begin
    osh  = osum_r >>> (5'd16 + {1'b0, oct_r});
    oval = osh[39:0];
    if (turb_r && oval[39]) begin
      oval = -oval;
    end
  end

  // Final offset, clamp and 8-bit scaling.
  logic signed [44:0] vsum;
  logic [55:0]        gt;
  logic [9:0]         gb;
  logic [7:0]         gray_nxt;
  always_comb begin
    vsum = 45'(acc_r) + (turb_r ? 45'sd0 : $signed(gnos_pkg::OFFSET_Q30));
    gt   = {fprod_r, 8'b0} - {8'b0, fprod_r};
    gb   = gt[55:46];
    if (!vpos_r) begin
      gray_nxt = 8'd0;
    end else if (gb > 10'd255) begin
      gray_nxt = 8'd255;
    end else begin
      gray_nxt = gb[7:0];
    end
  end

  // Next state and memory read controls.
  always_comb begin
    state_nxt = state_r;
    perm_re   = 1'b0;
    grad_re   = 1'b0;
    perm_ra   = row_ix;
    unique case (state_r)
      gnos_pkg::ST_IDLE: begin
        if (in_acc && (in_operation == gnos_pkg::OP_EVAL)) begin
          state_nxt = gnos_pkg::ST_MX;
        end
      end
      gnos_pkg::ST_MX:   state_nxt = gnos_pkg::ST_DIVX;
      gnos_pkg::ST_DIVX: if (div_last) state_nxt = gnos_pkg::ST_MY;
      gnos_pkg::ST_MY:   state_nxt = gnos_pkg::ST_DIVY;
      gnos_pkg::ST_DIVY: begin
        if (div_last) begin
          state_nxt = tile_r ? gnos_pkg::ST_QX : gnos_pkg::ST_OINIT;
        end
      end
      gnos_pkg::ST_QX:    state_nxt = gnos_pkg::ST_DIVQX;
      gnos_pkg::ST_DIVQX: if (div_last) state_nxt = gnos_pkg::ST_QY;
      gnos_pkg::ST_QY:    state_nxt = gnos_pkg::ST_DIVQY;
      gnos_pkg::ST_DIVQY: if (div_last) state_nxt = gnos_pkg::ST_OINIT;
      gnos_pkg::ST_OINIT: state_nxt = gnos_pkg::ST_SQ;
      gnos_pkg::ST_SQ:    state_nxt = gnos_pkg::ST_CU;
      gnos_pkg::ST_CU:    state_nxt = gnos_pkg::ST_WF;
      gnos_pkg::ST_WF: begin
        state_nxt = (wsel_r == 2'd3) ? gnos_pkg::ST_RP : gnos_pkg::ST_SQ;
      end
      gnos_pkg::ST_RP: begin
        perm_re   = 1'b1;
        perm_ra   = row_ix;
        state_nxt = gnos_pkg::ST_CP;
      end
      gnos_pkg::ST_CP: begin
        perm_re   = 1'b1;
        perm_ra   = col_ix + perm_q_r;
        state_nxt = gnos_pkg::ST_GR;
      end
      gnos_pkg::ST_GR: begin
        grad_re   = 1'b1;
        state_nxt = gnos_pkg::ST_WXY;
      end
      gnos_pkg::ST_WXY:  state_nxt = gnos_pkg::ST_DOTX;
      gnos_pkg::ST_DOTX: state_nxt = gnos_pkg::ST_DOTY;
      gnos_pkg::ST_DOTY: state_nxt = gnos_pkg::ST_PROD;
      gnos_pkg::ST_PROD: begin
        state_nxt = (k_r == 2'd3) ? gnos_pkg::ST_OACC : gnos_pkg::ST_RP;
      end
      gnos_pkg::ST_OACC: begin
        state_nxt = (oct_r == detail_r) ? gnos_pkg::ST_FADD : gnos_pkg::ST_SQ;
      end
      gnos_pkg::ST_FADD: state_nxt = gnos_pkg::ST_FMUL;
      gnos_pkg::ST_FMUL: state_nxt = gnos_pkg::ST_FOUT;
      gnos_pkg::ST_FOUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = gnos_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gnos_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gnos_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r   <= 1'b0;
      turb_r   <= 1'b0;
      detail_r <= 4'd1;
      xscale_r <= 16'd8192;
      yscale_r <= 16'd8192;
      rw_r     <= 13'd256;
      rh_r     <= 13'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gnos_pkg::CFG_TILE:    tile_r   <= cfg_data[0];
        gnos_pkg::CFG_TURB:    turb_r   <= cfg_data[0];
        gnos_pkg::CFG_DETAIL:  detail_r <= cfg_data[3:0];
        gnos_pkg::CFG_XSCALE:  xscale_r <= cfg_data;
        gnos_pkg::CFG_YSCALE:  yscale_r <= cfg_data;
        gnos_pkg::CFG_RWIDTH:  rw_r     <= cfg_data[12:0];
        gnos_pkg::CFG_RHEIGHT: rh_r     <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Table memories.
  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == gnos_pkg::OP_LOAD_PERM)) begin
      perm_mem[in_table_index] <= in_perm_value;
    end
    if (in_acc && (in_operation == gnos_pkg::OP_LOAD_GRAD)) begin
      gx_mem[in_table_index] <= in_grad_x;
      gy_mem[in_table_index] <= in_grad_y;
    end
    if (perm_re) begin
      perm_q_r <= perm_mem[perm_ra];
    end
    if (grad_re) begin
      gx_q_r <= gx_mem[perm_q_r];
      gy_q_r <= gy_mem[perm_q_r];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == gnos_pkg::ST_FOUT) && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == gnos_pkg::ST_FOUT) && (!out_valid_r || !out_stall)) begin
      gray_r <= gray_nxt;
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    unique case (state_r)
      gnos_pkg::ST_IDLE: begin
        col_r <= in_column;
        row_r <= in_row;
      end
      gnos_pkg::ST_MX: begin
        dvd_r  <= {mul_p[27:0], 5'b0};
        dsr_r  <= rw_cl;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      gnos_pkg::ST_MY: begin
        dvd_r  <= {mul_p[27:0], 5'b0};
        dsr_r  <= rh_cl;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      gnos_pkg::ST_QX: begin
        dvd_r  <= {16'b0, pxs_r[32:16]};
        dsr_r  <= {8'b0, xclip};
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      gnos_pkg::ST_QY: begin
        dvd_r  <= {16'b0, pys_r[32:16]};
        dsr_r  <= {8'b0, yclip};
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      gnos_pkg::ST_DIVX, gnos_pkg::ST_DIVY,
      gnos_pkg::ST_DIVQX, gnos_pkg::ST_DIVQY: begin
        dvd_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        dcnt_r <= dcnt_r + 6'd1;
        if (div_last) begin
          if (state_r == gnos_pkg::ST_DIVX) pxs_r <= {15'b0, quo_nxt};
          if (state_r == gnos_pkg::ST_DIVY) pys_r <= {15'b0, quo_nxt};
          if (state_r == gnos_pkg::ST_DIVQX) am_r <= {8'b0, rem_nxt};
          if (state_r == gnos_pkg::ST_DIVQY) bm_r <= {8'b0, rem_nxt};
        end
      end
      gnos_pkg::ST_OINIT: begin
        mx_r   <= {15'b0, xclip};
        my_r   <= {15'b0, yclip};
        oct_r  <= '0;
        acc_r  <= '0;
        osum_r <= '0;
        wsel_r <= '0;
      end
      gnos_pkg::ST_SQ: sq_r   <= mul_p[32:0];
      gnos_pkg::ST_CU: cube_r <= mul_p[48:0];
      gnos_pkg::ST_WF: begin
        w_r[wsel_r] <= wnum[48:32];
        wsel_r      <= wsel_r + 2'd1;
        k_r         <= '0;
      end
      gnos_pkg::ST_WXY:  wxy_r <= mul_p[32:16];
      gnos_pkg::ST_DOTX: dot_r <= mul_p[33:0];
      gnos_pkg::ST_DOTY: dot_r <= dot_r + mul_p[33:0];
      gnos_pkg::ST_PROD: begin
        osum_r <= osum_r + 56'(mul_p);
        k_r    <= k_r + 2'd1;
      end
      gnos_pkg::ST_OACC: begin
        acc_r  <= acc_r + 44'(oval);
        osum_r <= '0;
        oct_r  <= oct_r + 4'd1;
        wsel_r <= '0;
        // Next octave doubles the position; residues follow one bit at a time.
        pxs_r  <= {pxs_r[46:0], 1'b0};
        pys_r  <= {pys_r[46:0], 1'b0};
        am_r   <= {am_r[18:0], pxs_r[15]};
        bm_r   <= {bm_r[18:0], pys_r[15]};
        mx_r   <= {mx_r[18:0], 1'b0};
        my_r   <= {my_r[18:0], 1'b0};
      end
      gnos_pkg::ST_FADD: begin
        vpos_r <= !vsum[44] && (vsum != 45'sd0);
        vc_r   <= (vsum > 45'sd2147483648) ? 32'h8000_0000 : vsum[31:0];
      end
      gnos_pkg::ST_FMUL: fprod_r <= mul_p[47:0];
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import gnos_pkg::*;

  // The run is stopped here if the pipeline hangs.
  localparam int CYCLE_LIMIT   = 20_000_000;
  localparam int DRAIN_CYCLES  = 1200;
  localparam int HOLDOFF_LEN   = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [TBL_IDX_W-1:0] in_table_index = '0;
  logic [TBL_IDX_W-1:0] in_perm_value = '0;
  logic signed [15:0] in_grad_x = '0;
  logic signed [15:0] in_grad_y = '0;
  logic [COORD_BITS-1:0] in_column = '0;
  logic [COORD_BITS-1:0] in_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_gray_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gradient_noise_octave_sum_core dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block's tables and registers, updated when the
  // block accepts a load or a register write.
  logic [5:0]         perm_tbl [TABLE_ENTRIES];
  logic signed [15:0] gx_tbl [TABLE_ENTRIES];
  logic signed [15:0] gy_tbl [TABLE_ENTRIES];
  logic        tile_r, turb_r;
  logic [3:0]  detail_r;
  logic [15:0] xscale_r, yscale_r;
  logic [12:0] rwidth_r, rheight_r;

  logic [7:0] gray_q [$];
  int errors = 0;
  longint cycles = 0;

  // Idle percentages for the sender and the receiver in the current phase.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint blend_weight(input longint v);
    longint unsigned u, num;
    u = (v < 0) ? -v : v;
    num = (64'd1 << 48) + 2 * u * u * u;
    num -= 3 * u * u * 64'd65536;
    return longint'(num >> 32);
  endfunction

  // One octave: four lattice corners blended with the smooth weight.
  function automatic longint octave_value(input longint unsigned px, input longint unsigned py,
                                          input int i, input longint unsigned xclip,
                                          input longint unsigned yclip);
    longint unsigned sx, sy, a, b, n, rix;
    longint fx, fy, vx, vy, wxy, dot, acc;
    sx = px << i;
    sy = py << i;
    a = sx >> 16;
    b = sy >> 16;
    fx = longint'(sx & 64'hFFFF);
    fy = longint'(sy & 64'hFFFF);
    acc = 0;
    for (int ci = 0; ci < 2; ci++) begin
      for (int cj = 0; cj < 2; cj++) begin
        vx = fx - ci * 65536;
        vy = fy - cj * 65536;
        if (tile_r) begin
          rix = (b + cj) % (yclip << i);
          n = ((a + ci) % (xclip << i)) + perm_tbl[rix[5:0]];
        end else begin
          rix = b + cj;
          n = a + ci + perm_tbl[rix[5:0]];
        end
        n = perm_tbl[n[5:0]];
        wxy = (blend_weight(vx) * blend_weight(vy)) >>> 16;
        dot = longint'(gx_tbl[n[5:0]]) * vx + longint'(gy_tbl[n[5:0]]) * vy;
        acc += wxy * dot;
      end
    end
    return acc >>> (16 + i);
  endfunction

  function automatic logic [7:0] pixel_gray(input logic [11:0] col, input logic [11:0] row);
    longint unsigned xs, ys, rw, rh, xclip, yclip, px, py, g;
    longint sum, o, v, off, fac;
    xs = xscale_r;
    ys = yscale_r;
    rw = rwidth_r;
    rh = rheight_r;
    xclip = 1;
    yclip = 1;
    if (xs < SCALE_MIN) xs = SCALE_MIN;
    if (xs > SCALE_MAX) xs = SCALE_MAX;
    if (ys < SCALE_MIN) ys = SCALE_MIN;
    if (ys > SCALE_MAX) ys = SCALE_MAX;
    if (rw < 1) rw = 1;
    if (rw > REGION_MAX) rw = REGION_MAX;
    if (rh < 1) rh = 1;
    if (rh > REGION_MAX) rh = REGION_MAX;
    if (tile_r) begin
      xs = ((xs + 2047) >> 11) << 11;
      ys = ((ys + 2047) >> 11) << 11;
      xclip = xs >> 11;
      yclip = ys >> 11;
    end
    px = ((longint'(col) * xs) << 5) / rw;
    py = ((longint'(row) * ys) << 5) / rh;
    sum = 0;
    for (int i = 0; i <= detail_r; i++) begin
      o = octave_value(px, py, i, xclip, yclip);
      if (turb_r && o < 0) o = -o;
      sum += o;
    end
    off = turb_r ? 0 : longint'(OFFSET_Q30);
    fac = turb_r ? longint'(FACTOR_UNITY) : longint'(FACTOR_Q16);
    v = sum + off;
    if (v <= 0) return 8'd0;
    if (v > (64'sd1 <<< 31)) v = 64'sd1 <<< 31;
    g = (longint'(v) * fac * 255) >> 46;
    return (g > 255) ? 8'd255 : g[7:0];
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result checker: every accepted gray value is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (gray_q.size() == 0) begin
        report_mismatch("unexpected gray_value", out_gray_value, -1);
      end else begin
        if (out_gray_value !== gray_q[0])
          report_mismatch("gray_value", out_gray_value, gray_q[0]);
        void'(gray_q.pop_front());
      end
    end
  end

  // Receiver: random stalls per phase, plus a long hold-off on request that
  // lets the output register fill and back-pressure the input.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Offers one item, with random idle cycles first, and updates the shadow
  // state once the block has taken it.
  task automatic send_item(input op_t op, input logic [5:0] idx, input logic [5:0] pv,
                           input logic [15:0] gx, input logic [15:0] gy,
                           input logic [11:0] col, input logic [11:0] row);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_table_index <= idx;
    in_perm_value  <= pv;
    in_grad_x      <= gx;
    in_grad_y      <= gy;
    in_column      <= col;
    in_row         <= row;
    do @(posedge clk); while (in_stall);
    case (op)
      OP_LOAD_PERM: perm_tbl[idx] = pv;
      OP_LOAD_GRAD: begin
        gx_tbl[idx] = gx;
        gy_tbl[idx] = gy;
      end
      OP_EVAL: gray_q.push_back(pixel_gray(col, row));
      default: ;
    endcase
  endtask

  task automatic end_items();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until all predicted results have arrived, then lets the sequencer
  // settle so a register write cannot land mid-pixel.
  task automatic drain();
    end_items();
    while (gray_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TILE:    tile_r = data[0];
      CFG_TURB:    turb_r = data[0];
      CFG_DETAIL:  detail_r = data[3:0];
      CFG_XSCALE:  xscale_r = data;
      CFG_YSCALE:  yscale_r = data;
      CFG_RWIDTH:  rwidth_r = data[12:0];
      CFG_RHEIGHT: rheight_r = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all_regs(input logic tile, input logic turb, input logic [3:0] det,
                              input logic [15:0] xs, input logic [15:0] ys,
                              input logic [15:0] rw, input logic [15:0] rh);
    write_reg(CFG_TILE, tile);
    write_reg(CFG_TURB, turb);
    write_reg(CFG_DETAIL, det);
    write_reg(CFG_XSCALE, xs);
    write_reg(CFG_YSCALE, ys);
    write_reg(CFG_RWIDTH, rw);
    write_reg(CFG_RHEIGHT, rh);
  endtask

  function automatic logic [15:0] rand_grad();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'sd16384;
    if (r == 1) return -16'sd16384;
    return 16'($signed($urandom_range(32766)) - 16383);
  endfunction

  task automatic eval_pixel(input logic [11:0] col, input logic [11:0] row);
    send_item(OP_EVAL, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom), col, row);
  endtask

  // Every table entry is written before any pixel can read it.
  task automatic test_table_fill();
    for (int k = 0; k < TABLE_ENTRIES; k++)
      send_item(OP_LOAD_PERM, k, (k == 0) ? 6'd63 : 6'($urandom), rand_grad(), rand_grad(),
                12'($urandom), 12'($urandom));
    for (int k = 0; k < TABLE_ENTRIES; k++)
      send_item(OP_LOAD_GRAD, k, 6'($urandom), rand_grad(), rand_grad(),
                12'($urandom), 12'($urandom));
  endtask

  // Corners of the pixel range, the ignored operation, and register extremes
  // including values that the block clamps.
  task automatic test_directed();
    eval_pixel(12'd0, 12'd0);
    eval_pixel(12'd4095, 12'd4095);
    send_item(OP_NONE, 6'd63, 6'd63, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
    eval_pixel(12'd300, 12'd17);
    drain();
    set_all_regs(1'b0, 1'b1, 4'd15, 16'd32768, 16'd205, 16'd1, 16'd4096);
    eval_pixel(12'd0, 12'd4095);
    eval_pixel(12'd4095, 12'd1);
    drain();
    set_all_regs(1'b1, 1'b0, 4'd15, 16'd205, 16'd32768, 16'd4096, 16'd1);
    eval_pixel(12'd4095, 12'd4095);
    eval_pixel(12'd1, 12'd2);
    drain();
    // Out-of-range registers: clamped scales and region sizes.
    set_all_regs(1'b1, 1'b1, 4'd0, 16'd0, 16'hFFFF, 16'd0, 16'h1FFF);
    write_reg(CFG_RESERVED, 16'hFFFF);
    eval_pixel(12'd4095, 12'd0);
    eval_pixel(12'd77, 12'd4095);
    drain();
    set_all_regs(1'b0, 1'b0, 4'd0, 16'd4000, 16'd30000, 16'd8191, 16'd2);
    eval_pixel(12'd4095, 12'd4095);
    eval_pixel(12'd1234, 12'd3);
    drain();
  endtask

  task automatic random_regs();
    logic [15:0] xs, ys, rw, rh;
    logic [3:0] det;
    xs = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768, 205));
    ys = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768, 205));
    rw = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 1));
    rh = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 1));
    // Mostly few octaves to keep the run short; the top level now and then.
    det = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(3));
    set_all_regs($urandom_range(1), $urandom_range(1), det, xs, ys, rw, rh);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 60)
      eval_pixel(12'($urandom), 12'($urandom));
    else if (r < 78)
      send_item(OP_LOAD_PERM, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                12'($urandom), 12'($urandom));
    else if (r < 96)
      send_item(OP_LOAD_GRAD, 6'($urandom), 6'($urandom), rand_grad(), rand_grad(),
                12'($urandom), 12'($urandom));
    else
      send_item(OP_NONE, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                12'($urandom), 12'($urandom));
  endtask

  // Random traffic split into segments, with a fresh register setting for
  // each segment.
  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        drain();
        random_regs();
      end
      random_item();
    end
    drain();
  endtask

  // Long receiver hold-off while pixels keep coming, then a sender pause
  // until everything has drained.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_all_regs(1'b0, 1'b0, 4'd0, 16'd8192, 16'd8192, 16'd256, 16'd256);
    holdoff_req++;
    for (int k = 0; k < 12; k++) eval_pixel(12'($urandom), 12'($urandom));
    end_items();
    while (gray_q.size() != 0) @(posedge clk);
    for (int k = 0; k < 12; k++) eval_pixel(12'($urandom), 12'($urandom));
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tile_r = 1'b0;
    turb_r = 1'b0;
    detail_r = 4'd1;
    xscale_r = 16'd8192;
    yscale_r = 16'd8192;
    rwidth_r = 13'd256;
    rheight_r = 13'd256;

    test_table_fill();
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 420);
    test_random_phase(85, 0, 400);
    test_random_phase(0, 85, 400);
    test_random_phase(14, 14, 420);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
src/gnos_pkg.sv
src/gradient_noise_octave_sum_core.sv
tb/sv/tb.sv
